FILE: sv/twdp_pkg.sv
// Package for the ternary-weight dot product block.
// Holds payload structs, default sizes and shared helpers; no dependencies.
package twdp_pkg;

  localparam int MAX_LANES     = 8;
  localparam int ACT_FIELD_W   = 16;
  localparam int DOT_SUM_W     = 32;
  localparam int LANES_DEF     = 8;
  localparam int ACT_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF = 32;

  typedef struct packed {
    logic signed [ACT_FIELD_W-1:0] act_0;
    logic signed [ACT_FIELD_W-1:0] act_1;
    logic signed [ACT_FIELD_W-1:0] act_2;
    logic signed [ACT_FIELD_W-1:0] act_3;
    logic signed [ACT_FIELD_W-1:0] act_4;
    logic signed [ACT_FIELD_W-1:0] act_5;
    logic signed [ACT_FIELD_W-1:0] act_6;
    logic signed [ACT_FIELD_W-1:0] act_7;
    logic        [MAX_LANES-1:0]   plus_mask;
    logic        [MAX_LANES-1:0]   minus_mask;
    logic        [3:0]             lanes_valid;
    logic                          row_end;
  } twdp_in_t;

  typedef struct packed {
    logic signed [DOT_SUM_W-1:0] dot_sum;
    logic                        saturated;
  } twdp_out_t;

  // Merge-stage item handed to the accumulator.
  typedef struct packed {
    logic valid;
    logic row_end;
  } twdp_acc_req_t;

  // Activation of one lane, picked by lane number.
  function automatic logic signed [ACT_FIELD_W-1:0] act_of(twdp_in_t d, logic [2:0] idx);
    logic signed [ACT_FIELD_W-1:0] a;
    case (idx)
      3'd0:    a = d.act_0;
      3'd1:    a = d.act_1;
      3'd2:    a = d.act_2;
      3'd3:    a = d.act_3;
      3'd4:    a = d.act_4;
      3'd5:    a = d.act_5;
      3'd6:    a = d.act_6;
      3'd7:    a = d.act_7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/ternary_weight_dot_product_top.sv
// Top level of the ternary-weight dot product block.
// Depends on twdp_pkg, twdp_lane, twdp_merge and twdp_acc.
//
// Streams a row of activations against ternary weights given as a +1 mask and
// a -1 mask, up to eight lanes per transaction. Each lane adds, subtracts or
// drops its activation (both mask bits set counts as zero, lanes at or above
// lanes_valid are ignored). The lane sums of one transaction are added to a
// signed ACC_WIDTH-bit accumulator in one saturating step; a clip sets a
// sticky flag. The transaction with row_end set produces one result (dot_sum,
// saturated) and clears both. Throughput is one transaction per cycle unless a
// row end waits on a held result; the accumulator's single add-and-compare per
// cycle is the only feedback path. An accepted transaction loads the lane
// register, then the merge (lane adder) register, then the accumulator and
// result register, which raises out_valid. A result
// held by a stalled consumer blocks only row-end transactions reaching the
// accumulator; the lane and merge stages keep filling meanwhile.
module ternary_weight_dot_product_top
  import twdp_pkg::*;
#(
  parameter int LANES     = LANES_DEF,
  parameter int ACT_WIDTH = ACT_WIDTH_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  twdp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output twdp_out_t out_data
);

  localparam int DW = ACT_WIDTH + 1 + $clog2(LANES);

  logic                      v1_r, v1_nxt;
  logic                      v2_r, v2_nxt;
  logic                      end1_r, end2_r;
  logic                      ld1, ld2, go;
  logic signed [ACT_WIDTH:0] contrib [LANES];
  logic signed [DW-1:0]      delta;
  twdp_acc_req_t             acc_req;

  // stage handshake: a stage loads when empty or when its item moves on
  assign ld2      = v1_r && (!v2_r || go);
  assign in_ready = !v1_r || ld2;
  assign ld1      = in_valid && in_ready;

  assign v1_nxt = ld1 || (v1_r && !ld2);
  assign v2_nxt = ld2 || (v2_r && !go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      end1_r <= in_data.row_end;
    end
    if (ld2) begin
      end2_r <= end1_r;
    end
  end

  // lane stage
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    twdp_lane #(
      .ACT_WIDTH (ACT_WIDTH)
    ) u_lane (
      .clk       (clk),
      .load      (ld1),
      .act       (act_of(in_data, 3'(i))),
      .plus_bit  (in_data.plus_mask[i]),
      .minus_bit (in_data.minus_mask[i]),
      .lane_on   (4'(i) < in_data.lanes_valid),
      .contrib_r (contrib[i])
    );
  end

  // merge stage
  twdp_merge #(
    .LANES     (LANES),
    .ACT_WIDTH (ACT_WIDTH),
    .DW        (DW)
  ) u_merge (
    .clk     (clk),
    .load    (ld2),
    .contrib (contrib),
    .delta_r (delta)
  );

  // accumulate, saturate, hold result
  assign acc_req.valid   = v2_r;
  assign acc_req.row_end = end2_r;

  twdp_acc #(
    .ACC_WIDTH (ACC_WIDTH),
    .DW        (DW)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (acc_req),
    .delta       (delta),
    .go          (go),
    .out_valid_r (out_valid),
    .out_ready   (out_ready),
    .out_data_r  (out_data)
  );

endmodule

FILE: sv/twdp_lane.sv
// One activation lane: applies the ternary weight and registers the contribution.
// Depends on twdp_pkg.
module twdp_lane
  import twdp_pkg::*;
#(
  parameter int ACT_WIDTH = ACT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [ACT_FIELD_W-1:0] act,
  input  logic                          plus_bit,
  input  logic                          minus_bit,
  input  logic                          lane_on,
  output logic signed [ACT_WIDTH:0]     contrib_r
);

  localparam int CW = ACT_WIDTH + 1;

  logic signed [31:0]          act32;
  logic signed [ACT_WIDTH-1:0] act_a;
  logic signed [CW-1:0]        act_ext;
  logic signed [CW-1:0]        contrib_nxt;

  // low ACT_WIDTH bits of the field, sign-extended
  assign act32   = 32'(act);
  assign act_a   = act32[ACT_WIDTH-1:0];
  assign act_ext = CW'(act_a);

  always_comb begin
    contrib_nxt = '0;
    if (lane_on && plus_bit && !minus_bit) begin
      contrib_nxt = act_ext;
    end else if (lane_on && minus_bit && !plus_bit) begin
      contrib_nxt = -act_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      contrib_r <= contrib_nxt;
    end
  end

endmodule

FILE: sv/twdp_merge.sv
// Merge stage: sums the registered lane contributions into one item delta.
// Depends on twdp_pkg.
module twdp_merge
  import twdp_pkg::*;
#(
  parameter int LANES     = LANES_DEF,
  parameter int ACT_WIDTH = ACT_WIDTH_DEF,
  parameter int DW        = ACT_WIDTH + 1 + $clog2(LANES)
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic signed [ACT_WIDTH:0] contrib [LANES],
  output logic signed [DW-1:0]      delta_r
);

  logic signed [DW-1:0] delta_nxt;

  always_comb begin
    delta_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      delta_nxt = delta_nxt + DW'(contrib[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      delta_r <= delta_nxt;
    end
  end

endmodule

FILE: sv/twdp_acc.sv
// Saturating row accumulator with sticky clip flag and result register.
// Depends on twdp_pkg.
module twdp_acc
  import twdp_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF,
  parameter int DW        = ACT_WIDTH_DEF + 1 + $clog2(LANES_DEF)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  twdp_acc_req_t        req,
  input  logic signed [DW-1:0] delta,
  output logic                 go,
  output logic                 out_valid_r,
  input  logic                 out_ready,
  output twdp_out_t            out_data_r
);

  localparam int SW = ((ACC_WIDTH > DW) ? ACC_WIDTH : DW) + 1;
  localparam int MW = (ACC_WIDTH > DOT_SUM_W) ? ACC_WIDTH : DOT_SUM_W;
  localparam logic signed [SW-1:0] ACC_HI =
    {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic                        clip_r, clip_nxt;
  logic                        out_valid_nxt;
  logic signed [SW-1:0]        sum;
  logic                        over, under, clip_now;
  logic signed [ACC_WIDTH-1:0] sat;
  logic signed [MW-1:0]        sat_wide;

  assign sum      = SW'(acc_r) + SW'(delta);
  assign over     = sum > ACC_HI;
  assign under    = sum < ACC_LO;
  assign clip_now = clip_r | over | under;

  always_comb begin
    sat = sum[ACC_WIDTH-1:0];
    if (over) begin
      sat = ACC_HI[ACC_WIDTH-1:0];
    end else if (under) begin
      sat = ACC_LO[ACC_WIDTH-1:0];
    end
  end

  assign sat_wide = MW'(sat);

  // a row end needs a free result register
  assign go = req.valid && (!req.row_end || !out_valid_r || out_ready);

  always_comb begin
    acc_nxt       = acc_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (go) begin
      if (req.row_end) begin
        acc_nxt       = '0;
        clip_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt  = sat;
        clip_nxt = clip_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && req.row_end) begin
      out_data_r.dot_sum   <= sat_wide[DOT_SUM_W-1:0];
      out_data_r.saturated <= clip_now;
    end
  end

endmodule

FILE: sv/twdp_checker.sv
// Port-level checks for the ternary-weight dot product block, bound to the top.
// Depends on twdp_pkg and ternary_weight_dot_product_top.
module twdp_checker
  import twdp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input twdp_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input twdp_out_t out_data
);

  logic [2:0] pend_r, pend_nxt;
  logic       row_in, res_out;

  // row ends accepted but not yet delivered
  assign row_in   = in_valid && in_ready && in_data.row_end;
  assign res_out  = out_valid && out_ready;
  assign pend_nxt = pend_r + 3'(row_in) - 3'(res_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    res_out |-> pend_r != 3'd0)
    else $error("result without a pending row end");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more pending rows than pipeline stages");

endmodule

bind ternary_weight_dot_product_top twdp_checker u_twdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
